// ===== rtl/fixed_block_fit_allocator_assert.svh =====
// assertion macros for the fixed block fit allocator
// no dependencies; taken in by every module that carries checks
`ifndef FIXED_BLOCK_FIT_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FIT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
// check on every rising clock edge once out of reset
`define FBFA_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
	else $error("fbfa assertion failed");
// check on every rising clock edge, reset included
`define FBFA_ASSERT_ALWAYS(lbl, clk_s, prop) \
	lbl: assert property (@(posedge clk_s) prop) \
	else $error("fbfa assertion failed");
`else
`define FBFA_ASSERT(lbl, clk_s, rstn_s, prop)
`define FBFA_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

// ===== rtl/fbfa_pkg.sv =====
// shared types, codes and helpers of the fixed block fit allocator
// no dependencies
package fbfa_pkg;

	// field widths
	localparam int unsigned REQ_TYPE_W = 1;
	localparam int unsigned AMOUNT_W   = 5;
	localparam int unsigned OWNER_W    = 4;
	localparam int unsigned INDEX_W    = 4;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned MODE_W     = 2;

	// request codes
	localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 1'b0;
	localparam logic [REQ_TYPE_W-1:0] REQ_FREE  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	// placement policy codes; the unused code behaves as first fit
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic out_free;
	} sts_t;

	// pool offset of a block, 2^idx - 1 kept to four bits
	function automatic logic [INDEX_W-1:0] block_offset4(input logic [INDEX_W-1:0] idx);
		logic [INDEX_W:0] one_hot;
		one_hot = (INDEX_W+1)'(1) << idx;
		if (idx >= INDEX_W'(INDEX_W))
			return '1;
		return INDEX_W'(one_hot - (INDEX_W+1)'(1));
	endfunction

endpackage

// ===== rtl/fixed_block_fit_allocator.sv =====
// top level of the fixed block fit allocator
// depends on fbfa_pkg, fbfa_ctrl and fbfa_dpath
//
//  port group   direction  handshake              payload
//  request      in         req_valid / req_ready  req_type, amount, owner_id, free_index
//  result       out        res_valid / res_ready  status, chosen_block, block_offset, space_left
//  config       in         cfg_we                 cfg_wdata (fit mode)
//
// an allocate runs the fit scan, which reads one block of the table per cycle, then a commit
// step that updates the table and loads the result register; a free skips the scan and goes
// straight to the commit.
// the next item is taken in the commit cycle, while the result waits in the output register;
// a stalled result holds the commit, and with it the next item, until res_ready.
// reset clears the block table and sets first fit.
module fixed_block_fit_allocator #(
	parameter int unsigned NUM_BLOCKS = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fbfa_pkg::MODE_W-1:0]       cfg_wdata,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [fbfa_pkg::REQ_TYPE_W-1:0]   req_type,
	input  logic [fbfa_pkg::AMOUNT_W-1:0]     amount,
	input  logic [fbfa_pkg::OWNER_W-1:0]      owner_id,
	input  logic [fbfa_pkg::INDEX_W-1:0]      free_index,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [fbfa_pkg::STATUS_W-1:0]     status,
	output logic [fbfa_pkg::INDEX_W-1:0]      chosen_block,
	output logic [fbfa_pkg::INDEX_W-1:0]      block_offset,
	output logic [fbfa_pkg::AMOUNT_W-1:0]     space_left
);
	import fbfa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	fbfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_type),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// block table and fit scan
	fbfa_dpath #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_type     (req_type),
		.amount       (amount),
		.owner_id     (owner_id),
		.free_index   (free_index),
		.cmd          (cmd),
		.sts          (sts),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.status       (status),
		.chosen_block (chosen_block),
		.block_offset (block_offset),
		.space_left   (space_left)
	);

endmodule

// ===== rtl/fbfa_ctrl.sv =====
// controller state machine of the fixed block fit allocator
// depends on fbfa_pkg and fixed_block_fit_allocator_assert.svh
`include "fixed_block_fit_allocator_assert.svh"
module fbfa_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic [fbfa_pkg::REQ_TYPE_W-1:0]   req_type,
	output logic                              req_ready,
	input  fbfa_pkg::sts_t                    sts,
	output fbfa_pkg::cmd_t                    cmd
);
	import fbfa_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// ready when idle, or when the finishing item can leave this cycle
	assign req_ready = (state_q == ST_IDLE) || ((state_q == ST_FINISH) && sts.out_free);
	assign accept    = req_valid && req_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = (req_type == REQ_FREE) ? ST_FINISH : ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_last)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					if (accept)
						state_d = (req_type == REQ_FREE) ? ST_FINISH : ST_SCAN;
					else
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd        = '0;
		cmd.load   = accept;
		cmd.scan   = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_FINISH) && sts.out_free;
	end

	`FBFA_ASSERT(a_no_accept_in_scan, clk, arst_n, (state_q == ST_SCAN) |-> !req_ready)
	`FBFA_ASSERT(a_last_goes_finish, clk, arst_n, ((state_q == ST_SCAN) && sts.scan_last) |=> (state_q == ST_FINISH))
	`FBFA_ASSERT(a_commit_from_finish, clk, arst_n, cmd.commit |-> ((state_q == ST_FINISH) && !cmd.scan))

endmodule

// ===== rtl/fbfa_dpath.sv =====
// datapath of the fixed block fit allocator: block table, fit scan, result register
// depends on fbfa_pkg and fixed_block_fit_allocator_assert.svh
`include "fixed_block_fit_allocator_assert.svh"
module fbfa_dpath #(
	parameter int unsigned NUM_BLOCKS = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fbfa_pkg::MODE_W-1:0]       cfg_wdata,
	input  logic [fbfa_pkg::REQ_TYPE_W-1:0]   req_type,
	input  logic [fbfa_pkg::AMOUNT_W-1:0]     amount,
	input  logic [fbfa_pkg::OWNER_W-1:0]      owner_id,
	input  logic [fbfa_pkg::INDEX_W-1:0]      free_index,
	input  fbfa_pkg::cmd_t                    cmd,
	output fbfa_pkg::sts_t                    sts,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [fbfa_pkg::STATUS_W-1:0]     status,
	output logic [fbfa_pkg::INDEX_W-1:0]      chosen_block,
	output logic [fbfa_pkg::INDEX_W-1:0]      block_offset,
	output logic [fbfa_pkg::AMOUNT_W-1:0]     space_left
);
	import fbfa_pkg::*;

	localparam int unsigned IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	// a block holds up to 2^(NUM_BLOCKS-1) units; never narrower than an amount
	localparam int unsigned CW = (NUM_BLOCKS > AMOUNT_W) ? NUM_BLOCKS : AMOUNT_W;

	// block table
	logic [CW-1:0]         used_q [NUM_BLOCKS];
	logic [OWNER_W-1:0]    owner_q [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] owner_vld_q;
	logic [MODE_W-1:0]     fit_mode_q;

	// captured request
	logic [REQ_TYPE_W-1:0] req_type_q;
	logic [AMOUNT_W-1:0]   amount_q;
	logic [OWNER_W-1:0]    owner_id_q;
	logic [INDEX_W-1:0]    free_index_q;

	// scan state
	logic [IW-1:0] idx_q;
	logic          found_q;
	logic [IW-1:0] pick_q;
	logic [CW-1:0] best_left_q;
	logic [CW-1:0] best_used_q;

	// result register
	logic                res_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [INDEX_W-1:0]  chosen_q;
	logic [INDEX_W-1:0]  offset_q;
	logic [AMOUNT_W-1:0] space_q;

	logic [CW-1:0]       size_scan;
	logic [CW-1:0]       space_scan;
	logic [CW-1:0]       amt_ext;
	logic [CW-1:0]       left_scan;
	logic [CW-1:0]       used_next;
	logic                fits;
	logic                better;
	logic                free_ok;
	logic [IW-1:0]       free_idx;
	logic [CW-1:0]       size_free;
	logic [STATUS_W-1:0] status_d;
	logic [INDEX_W-1:0]  chosen_d;
	logic [INDEX_W-1:0]  offset_d;
	logic [AMOUNT_W-1:0] space_d;

	// free space of the block under scan and what is left after placing
	assign size_scan  = CW'(1) << idx_q;
	assign space_scan = (used_q[idx_q] >= size_scan) ? '0 : size_scan - used_q[idx_q];
	assign amt_ext    = CW'(amount_q);
	assign fits       = (space_scan >= amt_ext);
	assign left_scan  = space_scan - amt_ext;
	assign used_next  = used_q[idx_q] + amt_ext;

	// policy compare, ties keep the lower index
	always_comb begin
		case (fit_mode_q)
			MODE_BEST:  better = !found_q || (left_scan < best_left_q);
			MODE_WORST: better = !found_q || (left_scan > best_left_q);
			default:    better = !found_q;
		endcase
	end

	// free request decode
	assign free_ok   = ((INDEX_W+1)'(free_index_q) < (INDEX_W+1)'(NUM_BLOCKS));
	assign free_idx  = free_index_q[IW-1:0];
	assign size_free = CW'(1) << free_idx;

	// result of the item being finished
	always_comb begin
		status_d = STATUS_DONE;
		chosen_d = '0;
		offset_d = '0;
		space_d  = '0;
		if (req_type_q == REQ_FREE) begin
			if (free_ok) begin
				chosen_d = free_index_q;
				offset_d = block_offset4(free_index_q);
				space_d  = size_free[AMOUNT_W-1:0];
			end else begin
				status_d = STATUS_RANGE;
			end
		end else begin
			if (found_q) begin
				chosen_d = INDEX_W'(pick_q);
				offset_d = block_offset4(INDEX_W'(pick_q));
				space_d  = best_left_q[AMOUNT_W-1:0];
			end else begin
				status_d = STATUS_NOFIT;
			end
		end
	end

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= MODE_FIRST;
		end else if (cfg_we) begin
			fit_mode_q <= cfg_wdata;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q   <= req_type;
			amount_q     <= amount;
			owner_id_q   <= owner_id;
			free_index_q <= free_index;
		end
	end

	// scan counter and running choice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.load) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan) begin
			idx_q <= idx_q + IW'(1);
			if (fits && better)
				found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && fits && better) begin
			pick_q      <= idx_q;
			best_left_q <= left_scan;
			best_used_q <= used_next;
		end
	end

	// block table update on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				used_q[i]  <= '0;
				owner_q[i] <= '0;
			end
			owner_vld_q <= '0;
		end else if (cmd.commit) begin
			if (req_type_q == REQ_FREE) begin
				if (free_ok) begin
					used_q[free_idx]      <= '0;
					owner_q[free_idx]     <= '0;
					owner_vld_q[free_idx] <= 1'b0;
				end
			end else if (found_q) begin
				used_q[pick_q]      <= best_used_q;
				owner_q[pick_q]     <= owner_id_q;
				owner_vld_q[pick_q] <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= status_d;
			chosen_q <= chosen_d;
			offset_q <= offset_d;
			space_q  <= space_d;
		end
	end

	assign sts.scan_last = (idx_q == IW'(NUM_BLOCKS - 1));
	assign sts.out_free  = !res_valid_q || res_ready;

	assign res_valid    = res_valid_q;
	assign status       = status_q;
	assign chosen_block = chosen_q;
	assign block_offset = offset_q;
	assign space_left   = space_q;

	`FBFA_ASSERT(a_commit_room, clk, arst_n, cmd.commit |-> (!res_valid_q || res_ready))

	for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_chk
		`FBFA_ASSERT(a_unowned_empty, clk, arst_n, !owner_vld_q[g] |-> ((used_q[g] == '0) && (owner_q[g] == '0)))
		`FBFA_ASSERT(a_used_in_size, clk, arst_n, used_q[g] <= (CW'(1) << g))
	end

endmodule

// ===== verif/tb_fixed_block_fit_allocator.sv =====
// testbench for the fixed block fit allocator: directed table, then random request phases
// depends on fbfa_pkg and fixed_block_fit_allocator; results are checked against a local model or typed row values
module tb_fixed_block_fit_allocator;
	import fbfa_pkg::*;

	localparam int unsigned NUM_BLOCKS = 5;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 82;
	// the spare policy code, which behaves as first fit
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] kind;
		logic [AMOUNT_W-1:0]   units;
		logic [OWNER_W-1:0]    owner;
		logic [INDEX_W-1:0]    index;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  blk;
		logic [INDEX_W-1:0]  offset;
		logic [AMOUNT_W-1:0] space;
	} result_t;

	typedef struct {
		logic [MODE_W-1:0] mode;
		request_t          rq;
		bit                typed;
		result_t           res;
	} directed_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [MODE_W-1:0]     cfg_wdata = '0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	logic [REQ_TYPE_W-1:0] req_type = '0;
	logic [AMOUNT_W-1:0]   amount = '0;
	logic [OWNER_W-1:0]    owner_id = '0;
	logic [INDEX_W-1:0]    free_index = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [INDEX_W-1:0]    chosen_block;
	logic [INDEX_W-1:0]    block_offset;
	logic [AMOUNT_W-1:0]   space_left;

	// model of the block table and the policy register
	int                    units_in_use [NUM_BLOCKS];
	logic [OWNER_W-1:0]    block_owner [NUM_BLOCKS];
	bit                    block_owned [NUM_BLOCKS];
	logic [MODE_W-1:0]     policy = MODE_FIRST;

	result_t               pending_results [$];
	int                    mismatch_count = 0;
	int                    quiet_cycles = 0;
	int                    ready_hold = 0;
	bit                    sender_quiet = 1'b0;

	fixed_block_fit_allocator #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req_type),
		.amount      (amount),
		.owner_id    (owner_id),
		.free_index  (free_index),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.status      (status),
		.chosen_block(chosen_block),
		.block_offset(block_offset),
		.space_left  (space_left)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int block_units(int idx);
		return 1 << idx;
	endfunction

	function automatic int free_units(int idx);
		return (units_in_use[idx] >= block_units(idx)) ? 0 : block_units(idx) - units_in_use[idx];
	endfunction

	// mostly short idle spells, now and then a long one
	function automatic int idle_length();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 25);
		return $urandom_range(0, 2);
	endfunction

	// place an allocate or release a block, returning the result the block should give
	function automatic result_t place_or_release(request_t rq);
		result_t r;
		int      pick;
		int      best;
		int      spare;
		int      left;
		bit      found;
		r = '0;
		if (rq.kind == REQ_FREE) begin
			if (rq.index >= NUM_BLOCKS) begin
				r.status = STATUS_RANGE;
			end else begin
				units_in_use[rq.index] = 0;
				block_owner[rq.index] = '0;
				block_owned[rq.index] = 1'b0;
				r.status = STATUS_DONE;
				r.blk = rq.index;
				r.offset = INDEX_W'(block_units(rq.index) - 1);
				r.space = AMOUNT_W'(block_units(rq.index));
			end
			return r;
		end
		pick = 0;
		best = 0;
		found = 1'b0;
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			spare = free_units(i);
			if (spare < int'(rq.units))
				continue;
			left = spare - int'(rq.units);
			case (policy)
				MODE_BEST: begin
					if (!found || left < best) begin
						best = left;
						pick = i;
						found = 1'b1;
					end
				end
				MODE_WORST: begin
					if (!found || left > best) begin
						best = left;
						pick = i;
						found = 1'b1;
					end
				end
				default: begin
					if (!found) begin
						pick = i;
						found = 1'b1;
					end
				end
			endcase
		end
		if (!found) begin
			r.status = STATUS_NOFIT;
			return r;
		end
		units_in_use[pick] += int'(rq.units);
		block_owner[pick] = rq.owner;
		block_owned[pick] = 1'b1;
		r.status = STATUS_DONE;
		r.blk = INDEX_W'(pick);
		r.offset = INDEX_W'(block_units(pick) - 1);
		r.space = AMOUNT_W'(free_units(pick));
		return r;
	endfunction

	// offer one request item, hold it until taken, then queue its expected result
	task automatic send_request(request_t rq, bit typed, result_t typed_res);
		int      gap;
		result_t predicted;
		gap = sender_quiet ? 0 : idle_length();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		req_type   <= rq.kind;
		amount     <= rq.units;
		owner_id   <= rq.owner;
		free_index <= rq.index;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predicted = place_or_release(rq);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	// change the policy once the block has drained
	task automatic write_policy(logic [MODE_W-1:0] mode);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		policy = mode;
	endtask

	// result side stalls, held for random spells
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready  <= 1'b0;
			ready_hold <= 0;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			res_ready  <= ($urandom_range(0, 2) != 0);
			ready_hold <= idle_length();
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result item: status %0d block %0d", status, chosen_block);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					mismatch_count++;
				end
				if (chosen_block !== want.blk) begin
					$error("chosen_block: expected %0d, actual %0d", want.blk, chosen_block);
					mismatch_count++;
				end
				if (block_offset !== want.offset) begin
					$error("block_offset: expected %0d, actual %0d", want.offset, block_offset);
					mismatch_count++;
				end
				if (space_left !== want.space) begin
					$error("space_left: expected %0d, actual %0d", want.space, space_left);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles where neither side moves an item
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (res_valid && res_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL fixed_block_fit_allocator");
				$finish;
			end
		end
	end

	initial begin
		directed_row_t directed [];
		request_t      rq;
		int            roll;
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			units_in_use[i] = 0;
			block_owner[i] = '0;
			block_owned[i] = 1'b0;
		end
		// mode, {type, amount, owner, index}, typed, {status, block, offset, space}
		directed = '{
			'{MODE_FIRST, {REQ_ALLOC, 5'd0,  4'd0,  4'd0},  1'b1, {STATUS_DONE,  4'd0, 4'd0,  5'd1}},
			'{MODE_FIRST, {REQ_ALLOC, 5'd16, 4'd15, 4'd0},  1'b1, {STATUS_DONE,  4'd4, 4'd15, 5'd0}},
			'{MODE_FIRST, {REQ_ALLOC, 5'd31, 4'd9,  4'd15}, 1'b1, {STATUS_NOFIT, 4'd0, 4'd0,  5'd0}},
			'{MODE_FIRST, {REQ_FREE,  5'd31, 4'd15, 4'd15}, 1'b1, {STATUS_RANGE, 4'd0, 4'd0,  5'd0}},
			'{MODE_FIRST, {REQ_FREE,  5'd0,  4'd0,  4'd5},  1'b1, {STATUS_RANGE, 4'd0, 4'd0,  5'd0}},
			'{MODE_FIRST, {REQ_FREE,  5'd0,  4'd0,  4'd4},  1'b1, {STATUS_DONE,  4'd4, 4'd15, 5'd16}},
			'{MODE_FIRST, {REQ_FREE,  5'd31, 4'd15, 4'd0},  1'b1, {STATUS_DONE,  4'd0, 4'd0,  5'd1}},
			'{MODE_FIRST, {REQ_ALLOC, 5'd1,  4'd3,  4'd0},  1'b0, '0},
			'{MODE_FIRST, {REQ_ALLOC, 5'd1,  4'd4,  4'd0},  1'b0, '0},
			'{MODE_BEST,  {REQ_ALLOC, 5'd3,  4'd5,  4'd0},  1'b0, '0},
			'{MODE_BEST,  {REQ_ALLOC, 5'd1,  4'd5,  4'd0},  1'b0, '0},
			'{MODE_BEST,  {REQ_ALLOC, 5'd0,  4'd2,  4'd0},  1'b0, '0},
			'{MODE_WORST, {REQ_ALLOC, 5'd2,  4'd6,  4'd0},  1'b0, '0},
			'{MODE_WORST, {REQ_ALLOC, 5'd16, 4'd6,  4'd0},  1'b1, {STATUS_NOFIT, 4'd0, 4'd0,  5'd0}},
			'{MODE_WORST, {REQ_FREE,  5'd0,  4'd0,  4'd3},  1'b1, {STATUS_DONE,  4'd3, 4'd7,  5'd8}},
			'{MODE_SPARE, {REQ_ALLOC, 5'd4,  4'd7,  4'd0},  1'b0, '0},
			'{MODE_SPARE, {REQ_ALLOC, 5'd8,  4'd8,  4'd0},  1'b0, '0},
			'{MODE_FIRST, {REQ_FREE,  5'd0,  4'd0,  4'd1},  1'b0, '0},
			'{MODE_FIRST, {REQ_ALLOC, 5'd0,  4'd15, 4'd15}, 1'b0, '0}
		};

		// reset
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, policy switched only when the row asks for another one
		foreach (directed[k]) begin
			if (directed[k].mode != policy)
				write_policy(directed[k].mode);
			send_request(directed[k].rq, directed[k].typed, directed[k].res);
		end

		// random phases, each under its own policy
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_policy((phase < 4) ? MODE_W'(phase) : MODE_W'($urandom_range(0, 3)));
			sender_quiet = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				rq.owner = OWNER_W'($urandom_range(0, 15));
				rq.units = AMOUNT_W'($urandom_range(0, 31));
				rq.index = INDEX_W'($urandom_range(0, 15));
				if ($urandom_range(0, 99) < 35) begin
					rq.kind = REQ_FREE;
					// mostly blocks that exist, some out of range
					if ($urandom_range(0, 99) < 85)
						rq.index = INDEX_W'($urandom_range(0, NUM_BLOCKS - 1));
				end else begin
					rq.kind = REQ_ALLOC;
					roll = $urandom_range(0, 99);
					if (roll < 60)
						rq.units = AMOUNT_W'($urandom_range(0, 4));
					else if (roll < 92)
						rq.units = AMOUNT_W'($urandom_range(5, 16));
				end
				send_request(rq, 1'b0, '0);
			end
		end

		// drain and let the block settle
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4 * NUM_BLOCKS + 4) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS fixed_block_fit_allocator");
		else
			$display("FAIL fixed_block_fit_allocator");
		$finish;
	end

endmodule
